// ----- hw/rtl/tbp_pkg.sv -----
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int LOCAL_HISTORY_BITS_DEF  = 12;
  localparam int GLOBAL_HISTORY_BITS_DEF = 14;
  localparam int PC_INDEX_BITS_DEF       = 12;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  // Counters: 0 strong NT .. 3 strong T. Chooser: 0 strong global .. 3 strong local.
  localparam logic [1:0] CTR_STRONG_NT     = 2'd0;
  localparam logic [1:0] CHOOSE_WEAK_LOCAL = 2'd2;

  typedef struct packed {
    logic clear;     // write reset values at the sweep address
    logic accept;    // capture the word, read history tables
    logic lct_read;  // read the local counter picked by the local history
    logic commit;    // load the prediction, write back on train
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep is at its final address
  } status_t;

  function automatic logic [1:0] sat_update(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != 2'd3) res = ctr + 2'd1;
    end else begin
      if (ctr != 2'd0) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/tbp_ctrl.sv -----
`timescale 1ns / 1ps

module tbp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tbp_pkg::status_t status_i,
  output tbp_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LCT,
    ST_EVAL
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.lct_read = (state_q == ST_LCT);
    cmd_o.commit   = (state_q == ST_EVAL) && out_free;
  end

  // load a new word on commit, otherwise hold until the receiver takes it
  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_valid_q && out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_LCT;
        end
        ST_LCT: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          // hold until the output register can take the word
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/tbp_datapath.sv -----
`timescale 1ns / 1ps

module tbp_datapath #(
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int PC_INDEX_BITS       = tbp_pkg::PC_INDEX_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tbp_pkg::cmd_t            cmd_i,
  output tbp_pkg::status_t         status_o,
  input  logic                     opcode_i,
  input  logic [PC_INDEX_BITS-1:0] pc_idx_i,
  input  logic                     outcome_i,
  output logic                     prediction_o
);

  localparam int LhBits = LOCAL_HISTORY_BITS;
  localparam int GhBits = GLOBAL_HISTORY_BITS;
  localparam int PcBits = PC_INDEX_BITS;
  localparam int MaxLp  = (LhBits > PcBits) ? LhBits : PcBits;
  localparam int ClrBits = (GhBits > MaxLp) ? GhBits : MaxLp;

  logic [LhBits-1:0] lht [2**PcBits];
  logic [1:0]        lct [2**LhBits];
  logic [1:0]        gct [2**GhBits];
  logic [1:0]        cht [2**GhBits];

  logic [ClrBits-1:0] clr_q;
  logic [GhBits-1:0]  ghist_q;
  logic               op_q;
  logic               outcome_q;
  logic [PcBits-1:0]  pc_q;
  logic [LhBits-1:0]  lhist_q;
  logic [1:0]         gctr_q;
  logic [1:0]         choice_q;
  logic [1:0]         lctr_q;
  logic               pred_q;

  logic       lpred;
  logic       gpred;
  logic       pred;
  logic       train_wr;
  logic [1:0] choice_new;

  assign status_o.clr_last = &clr_q;
  assign prediction_o      = pred_q;

  assign lpred    = lctr_q[1];
  assign gpred    = gctr_q[1];
  assign pred     = choice_q[1] ? lpred : gpred;
  assign train_wr = cmd_i.commit && (op_q == tbp_pkg::OP_TRAIN);

  always_comb begin
    choice_new = choice_q;
    // move toward whichever predictor alone was right
    if ((lpred == outcome_q) && (gpred != outcome_q)) begin
      choice_new = tbp_pkg::sat_update(choice_q, 1'b1);
    end else if ((gpred == outcome_q) && (lpred != outcome_q)) begin
      choice_new = tbp_pkg::sat_update(choice_q, 1'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      ghist_q <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (train_wr) ghist_q <= GhBits'({ghist_q, outcome_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= opcode_i;
      outcome_q <= outcome_i;
      pc_q      <= pc_idx_i;
    end
    if (cmd_i.commit) pred_q <= pred;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lht[clr_q[PcBits-1:0]] <= '0;
    end else if (train_wr) begin
      lht[pc_q] <= LhBits'({lhist_q, outcome_q});
    end
    if (cmd_i.accept) lhist_q <= lht[pc_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      lct[clr_q[LhBits-1:0]] <= tbp_pkg::CTR_STRONG_NT;
    end else if (train_wr) begin
      lct[lhist_q] <= tbp_pkg::sat_update(lctr_q, outcome_q);
    end
    if (cmd_i.lct_read) lctr_q <= lct[lhist_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      gct[clr_q[GhBits-1:0]] <= tbp_pkg::CTR_STRONG_NT;
    end else if (train_wr) begin
      gct[ghist_q] <= tbp_pkg::sat_update(gctr_q, outcome_q);
    end
    if (cmd_i.accept) gctr_q <= gct[ghist_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      cht[clr_q[GhBits-1:0]] <= tbp_pkg::CHOOSE_WEAK_LOCAL;
    end else if (train_wr) begin
      cht[ghist_q] <= choice_new;
    end
    if (cmd_i.accept) choice_q <= cht[ghist_q];
  end

endmodule

// ----- hw/rtl/tournament_branch_predictor_top.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_stall_o   opcode_i, pc_i, outcome_i
// out      output     out_valid_o / out_stall_i prediction_o
//
// Each word goes through history and global-index table reads, then the
// local counter read through the fetched local history, then evaluate and write back.
// After reset a clearing sweep over 2^max(LOCAL_HISTORY_BITS, GLOBAL_HISTORY_BITS,
// PC_INDEX_BITS) addresses (16384 by default) runs while in_stall_o is high.
// A held out_stall_i keeps the block in evaluate until the output register frees.

module tournament_branch_predictor_top #(
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int PC_INDEX_BITS       = tbp_pkg::PC_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] pc_i,
  input  logic        outcome_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        prediction_o
);

  tbp_pkg::cmd_t    cmd;
  tbp_pkg::status_t status;

  tbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbp_datapath #(
    .LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
    .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS),
    .PC_INDEX_BITS       (PC_INDEX_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .pc_idx_i     (pc_i[PC_INDEX_BITS-1:0]),
    .outcome_i    (outcome_i),
    .prediction_o (prediction_o)
  );

endmodule
